/* hw/rtl/ps2s2a_pkg.sv */
// Package: constants, queue entry type and scan code translation table.
`timescale 1ns / 1ps
package ps2s2a_pkg;

  // Ring buffer depth; one slot always stays empty
  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAR_W       = 7;
  localparam int CODE_W       = 8;

  // Request types
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Classified item handed from front to back
  typedef struct packed {
    logic              is_read;
    logic              is_push;
    logic [CHAR_W-1:0] ch;
  } op_t;

  // Ring pointer advance, wrapping at the buffer depth
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Set 1 make code to unshifted US ASCII; 0 means no character
  function automatic logic [CHAR_W-1:0] press_to_ascii(input logic [6:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      7'h01: ch = 7'd27;
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;
      7'h0E: ch = 7'd8;
      7'h0F: ch = 7'd9;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5B;
      7'h1B: ch = 7'h5D;
      7'h1C: ch = 7'd10;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/ps2s2a_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface ps2s2a_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ps2s2a_pkg::CODE_W-1:0] scan_code;

  modport source (output valid, req_type, scan_code, input ready);
  modport sink   (input valid, req_type, scan_code, output ready);
endinterface

interface ps2s2a_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ps2s2a_pkg::CHAR_W-1:0] char_out;
  logic                         not_empty;
  logic                         dropped;

  modport source (output valid, char_out, not_empty, dropped, input ready);
  modport sink   (input valid, char_out, not_empty, dropped, output ready);
endinterface

/* hw/rtl/ps2_scancode_to_ascii_fifo.sv */
// Top level: PS/2 set 1 scan code to ASCII translator with a character ring buffer.
// Each request is either a scan code (make codes are translated to unshifted US ASCII and
// stored; break codes and keys with no character are ignored) or a read that pops the
// oldest character, 0 if none. Every request yields exactly one result carrying the
// character read, whether characters remain, and whether a character was dropped because
// the 255-character buffer was full. The front end registers the translated request and
// a two-entry queue decouples it from the buffer; the buffer end takes one request per
// cycle while its result register is free or its result is taken, except that a read that
// finds a character holds off the next request until the character store, which has a
// registered read port, has delivered the character to the result.
`timescale 1ns / 1ps
module ps2_scancode_to_ascii_fifo (
  input  logic          clk,
  input  logic          rst,
  ps2s2a_req_if.sink    req,
  ps2s2a_rsp_if.source  rsp
);

  logic            f_valid;
  logic            f_ready;
  ps2s2a_pkg::op_t f_op;
  logic            q_valid;
  logic            q_ready;
  ps2s2a_pkg::op_t q_op;

  ps2s2a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  ps2s2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  ps2s2a_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (q_op),
    .rsp      (rsp)
  );

endmodule

/* hw/rtl/ps2s2a_front.sv */
// Front end: accepts items, translates scan codes and registers the classified op.
`timescale 1ns / 1ps
module ps2s2a_front (
  input  logic               clk,
  input  logic               rst,
  ps2s2a_req_if.sink         req,
  output logic               op_valid,
  input  logic               op_ready,
  output ps2s2a_pkg::op_t    op
);

  logic            hold_valid;
  logic            hold_valid_next;
  ps2s2a_pkg::op_t op_cls;

  // Classify the incoming item
  always_comb begin
    op_cls.is_read = (req.req_type == ps2s2a_pkg::REQ_READ);
    op_cls.ch      = ps2s2a_pkg::press_to_ascii(req.scan_code[6:0]);
    op_cls.is_push = (req.req_type == ps2s2a_pkg::REQ_SCAN) && !req.scan_code[7] &&
                     (op_cls.ch != '0);
  end

  assign req.ready = !hold_valid || op_ready;
  assign op_valid  = hold_valid;

  always_comb begin
    hold_valid_next = hold_valid;
    if (req.valid && req.ready) begin
      hold_valid_next = 1'b1;
    end else if (op_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op <= op_cls;
    end
  end

endmodule

/* hw/rtl/ps2s2a_queue.sv */
// Short queue of classified ops between front and back.
`timescale 1ns / 1ps
module ps2s2a_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ps2s2a_pkg::op_t in_op,
  output logic            out_valid,
  input  logic            out_ready,
  output ps2s2a_pkg::op_t out_op
);

  ps2s2a_pkg::op_t                 slots [ps2s2a_pkg::QUEUE_DEPTH];
  logic [ps2s2a_pkg::QPTR_W-1:0]   wr_idx;
  logic [ps2s2a_pkg::QPTR_W-1:0]   wr_idx_next;
  logic [ps2s2a_pkg::QPTR_W-1:0]   rd_idx;
  logic [ps2s2a_pkg::QPTR_W-1:0]   rd_idx_next;
  logic [ps2s2a_pkg::QCNT_W-1:0]   count;
  logic [ps2s2a_pkg::QCNT_W-1:0]   count_next;
  logic                            push;
  logic                            pop;

  function automatic logic [ps2s2a_pkg::QPTR_W-1:0] qadv(
      input logic [ps2s2a_pkg::QPTR_W-1:0] p);
    if (p == ps2s2a_pkg::QPTR_W'(ps2s2a_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ps2s2a_pkg::QPTR_W'(1);
  endfunction

  assign in_ready  = (count != ps2s2a_pkg::QCNT_W'(ps2s2a_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = slots[rd_idx];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_idx_next = push ? qadv(wr_idx) : wr_idx;
    rd_idx_next = pop ? qadv(rd_idx) : rd_idx;
    count_next  = count;
    if (push && !pop) begin
      count_next = count + ps2s2a_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - ps2s2a_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= in_op;
    end
  end

endmodule

/* hw/rtl/ps2s2a_back.sv */
// Back end: character ring buffer with pointers and the result register.
`timescale 1ns / 1ps
module ps2s2a_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  ps2s2a_pkg::op_t op,
  ps2s2a_rsp_if.source    rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic [ps2s2a_pkg::CHAR_W-1:0] mem [ps2s2a_pkg::BUFFER_DEPTH];
  logic [ps2s2a_pkg::CHAR_W-1:0] rd_data;

  logic                           state;
  logic                           state_next;
  logic [ps2s2a_pkg::PTR_W-1:0]   write_ptr;
  logic [ps2s2a_pkg::PTR_W-1:0]   write_ptr_next;
  logic [ps2s2a_pkg::PTR_W-1:0]   read_ptr;
  logic [ps2s2a_pkg::PTR_W-1:0]   read_ptr_next;
  logic                           out_valid;
  logic                           out_valid_next;
  logic [ps2s2a_pkg::CHAR_W-1:0]  char_out;
  logic [ps2s2a_pkg::CHAR_W-1:0]  char_out_next;
  logic                           not_empty;
  logic                           not_empty_next;
  logic                           dropped;
  logic                           dropped_next;

  logic is_empty;
  logic is_full;
  logic take;
  logic mem_we;
  logic mem_re;

  assign is_empty = (write_ptr == read_ptr);
  assign is_full  = (ps2s2a_pkg::ptr_adv(write_ptr) == read_ptr);
  assign op_ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign take     = op_valid && op_ready;
  assign mem_we   = take && op.is_push && !is_full;
  assign mem_re   = take && op.is_read && !is_empty;

  assign rsp.valid     = out_valid;
  assign rsp.char_out  = char_out;
  assign rsp.not_empty = not_empty;
  assign rsp.dropped   = dropped;

  // Op execution and result formation
  always_comb begin
    state_next     = state;
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    out_valid_next = out_valid && !rsp.ready;
    char_out_next  = char_out;
    not_empty_next = not_empty;
    dropped_next   = dropped;
    case (state)
      ST_IDLE: begin
        if (take) begin
          char_out_next = '0;
          dropped_next  = 1'b0;
          if (op.is_read) begin
            if (is_empty) begin
              out_valid_next = 1'b1;
              not_empty_next = 1'b0;
            end else begin
              // character comes from the registered read port next cycle
              read_ptr_next = ps2s2a_pkg::ptr_adv(read_ptr);
              state_next    = ST_RD;
            end
          end else if (op.is_push) begin
            out_valid_next = 1'b1;
            not_empty_next = 1'b1;
            if (is_full) begin
              dropped_next = 1'b1;
            end else begin
              write_ptr_next = ps2s2a_pkg::ptr_adv(write_ptr);
            end
          end else begin
            out_valid_next = 1'b1;
            not_empty_next = !is_empty;
          end
        end
      end
      ST_RD: begin
        out_valid_next = 1'b1;
        char_out_next  = rd_data;
        not_empty_next = !is_empty;
        dropped_next   = 1'b0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      write_ptr <= '0;
      read_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    char_out  <= char_out_next;
    not_empty <= not_empty_next;
    dropped   <= dropped_next;
  end

  // Character store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_ptr] <= op.ch;
    end
    if (mem_re) begin
      rd_data <= mem[read_ptr];
    end
  end

endmodule

/* hw/rtl/ps2s2a_checker.sv */
// Port-level checker for the translator and its bind to the top level.
`timescale 1ns / 1ps
module ps2s2a_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ps2s2a_pkg::CHAR_W-1:0] char_out,
  input logic                          not_empty,
  input logic                          dropped
);

  // A stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(char_out) && $stable(not_empty) &&
                                $stable(dropped))
    else $error("result changed while stalled");

  // A drop only happens on a full buffer, so characters remain
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> not_empty)
    else $error("drop reported with empty buffer");

  // A drop comes from a scan code item, which returns no character
  a_drop_nochar: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> char_out == '0)
    else $error("drop reported together with a character");

  // No result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind ps2_scancode_to_ascii_fifo ps2s2a_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .char_out  (rsp.char_out),
  .not_empty (rsp.not_empty),
  .dropped   (rsp.dropped)
);
